FILE: rtl/hsl_to_rgb_converter_core_defines.svh
// ---------------------------------------------------------------------------
// hsl_to_rgb_converter_core_defines
// assertion macros used by the checker file hrc_checker
// ---------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSL_TO_RGB_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define HRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hrc check failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define HRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hrc check failed");

`endif

FILE: rtl/hrc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrc_pkg
// constants and helpers for the hsl to rgb pixel pipeline
// ---------------------------------------------------------------------------
package hrc_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned OUT_MAX   = 255;

  localparam int unsigned IN_W   = 15;
  localparam int unsigned OUT_W  = 8;
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 24;

  // full scale of every input
  localparam logic [14:0] S_FULL  = 15'(100 << FRAC_BITS);
  localparam logic [17:0] THREE_S = 18'(3 * (100 << FRAC_BITS));
  localparam logic [17:0] SIX_S   = 18'(6 * (100 << FRAC_BITS));
  localparam logic [17:0] TWO_S   = 18'(2 * (100 << FRAC_BITS));
  localparam logic [17:0] FOUR_S  = 18'(4 * (100 << FRAC_BITS));
  localparam logic [30:0] HALF_S  = 31'((100 << FRAC_BITS) / 2);

  // floor(x / 100) = (x * RECIP_100) >> RECIP_100_SH for x < 2^22
  localparam logic [22:0] RECIP_100    = 23'd5368710;
  localparam int unsigned RECIP_100_SH = 29;

  // den = 3*S*S = 2^(2*FRAC_BITS) * 30000
  localparam int unsigned DEN_SH      = 2 * FRAC_BITS;
  localparam logic [40:0] HALF_DEN    = 41'd983040000;
  // floor(y / 30000) = (y * RECIP_DEN) >> RECIP_DEN_SH for y < 2^23
  localparam logic [23:0] RECIP_DEN    = 24'd9162597;
  localparam int unsigned RECIP_DEN_SH = 38;

  localparam int unsigned NSTG = 9;

  // clamped triangle wave of one channel, x below 10 full scales
  function automatic logic [14:0] tri_wave(input logic [17:0] x);
    logic [17:0] p;
    logic [17:0] d;
    logic [17:0] e;
    p = (x >= SIX_S) ? (x - SIX_S) : x;
    d = (p > THREE_S) ? (p - THREE_S) : (THREE_S - p);
    if (d <= 18'(S_FULL)) begin
      return '0;
    end
    e = d - 18'(S_FULL);
    if (e > 18'(S_FULL)) begin
      return S_FULL;
    end
    return 15'(e);
  endfunction

endpackage

FILE: rtl/hsl_to_rgb_converter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsl_to_rgb_converter_core
// nine-stage pixel pipeline converting hue, saturation, lightness to rgb
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                  | beat
//  s_axis   | in  | hue[14:0] sat[29:15] light[44:30], pad   | one pixel
//  m_axis   | out | red[7:0] green[15:8] blue[23:16]         | one pixel
//
//  one pixel per clock sustained when the output side is ready; the
//  multipliers set the stage split
//  every stage holds a valid bit, a stage loads when it is empty or its
//  successor loads, so bubbles close up and a stalled pixel just waits
//  rst_ni clears the valid bits only, data registers carry no reset
// ---------------------------------------------------------------------------
module hsl_to_rgb_converter_core import hrc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // hue[14:0], saturation[29:15], lightness[44:30], zero [47:45]
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // red[7:0], green[15:8], blue[23:16]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  // ---- valid / advance chain ----------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   adv;

  assign adv[NSTG] = m_axis_tready_i;
  for (genvar k = 0; k < NSTG; k++) begin : g_adv
    // a stage takes new data when empty or when its content moves on
    assign adv[k] = !vld_q[k] || adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready_o = adv[0];

  // ---- stage 1: hue wrap, clamps --------------------------------------------
  logic [IN_W-1:0] hue_in, sat_in, lig_in;
  logic [14:0]     h1_d, sat1_d, lig1_d;
  logic [14:0]     h1_q, sat1_q, lig1_q;

  assign hue_in = s_axis_tdata_i[IN_W-1:0];
  assign sat_in = s_axis_tdata_i[2*IN_W-1:IN_W];
  assign lig_in = s_axis_tdata_i[3*IN_W-1:2*IN_W];

  // hue is below twice full scale, so one subtract does the modulo
  assign h1_d   = (hue_in >= S_FULL) ? (hue_in - S_FULL) : hue_in;
  assign sat1_d = (sat_in > S_FULL) ? S_FULL : sat_in;
  assign lig1_d = (lig_in > S_FULL) ? S_FULL : lig_in;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      h1_q   <= h1_d;
      sat1_q <= sat1_d;
      lig1_q <= lig1_d;
    end
  end

  // ---- stage 2: triangle waves ----------------------------------------------
  logic [17:0]      h6;
  logic [2:0][14:0] c2_d, c2_q;
  logic [14:0]      sat2_q;
  logic [15:0]      l2_d, l2_q;
  logic             hi2_d, hi2_q;

  assign h6      = 18'(h1_q) * 18'd6;
  assign c2_d[0] = tri_wave(h6);
  // green leads by two thirds of a turn, blue by one third
  assign c2_d[1] = tri_wave(h6 + FOUR_S);
  assign c2_d[2] = tri_wave(h6 + TWO_S);
  assign l2_d    = {lig1_q, 1'b0};
  // exactly half lightness stays on the toward-black branch
  assign hi2_d   = l2_d > {1'b0, S_FULL};

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      c2_q   <= c2_d;
      sat2_q <= sat1_q;
      l2_q   <= l2_d;
      hi2_q  <= hi2_d;
    end
  end

  // ---- stage 3: lightness scale or blend ------------------------------------
  logic [2:0][29:0] n3_d, n3_q;
  logic [14:0]      sat3_q;

  always_comb begin
    logic [14:0] mul_a;
    logic [15:0] mul_b;
    logic [29:0] addv;
    logic [30:0] prod;
    for (int i = 0; i < 3; i++) begin
      if (hi2_q) begin
        // (2L - S) * (S - c) + c * S
        mul_a = S_FULL - c2_q[i];
        mul_b = l2_q - {1'b0, S_FULL};
        addv  = 30'(c2_q[i]) * 30'(S_FULL);
      end else begin
        // c * 2L
        mul_a = c2_q[i];
        mul_b = l2_q;
        addv  = '0;
      end
      prod    = 31'(mul_a) * 31'(mul_b);
      n3_d[i] = 30'(prod + 31'(addv));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      n3_q   <= n3_d;
      sat3_q <= sat2_q;
    end
  end

  // ---- stage 4: round by full scale, reciprocal product ---------------------
  logic [2:0][44:0] p4_d, p4_q;
  logic [14:0]      sat4_q;

  always_comb begin
    logic [30:0] rnd;
    logic [21:0] x;
    for (int i = 0; i < 3; i++) begin
      rnd     = 31'(n3_q[i]) + HALF_S;
      x       = 22'(rnd >> FRAC_BITS);
      p4_d[i] = 45'(x) * 45'(RECIP_100);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      p4_q   <= p4_d;
      sat4_q <= sat3_q;
    end
  end

  // ---- stage 5: lightness result and channel sum ----------------------------
  logic [2:0][14:0] q5_d, q5_q;
  logic [16:0]      qs5_d, qs5_q;
  logic [14:0]      sat5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q5_d[i] = 15'(p4_q[i] >> RECIP_100_SH);
    end
    qs5_d = 17'(q5_d[0]) + 17'(q5_d[1]) + 17'(q5_d[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      q5_q   <= q5_d;
      qs5_q  <= qs5_d;
      sat5_q <= sat4_q;
    end
  end

  // ---- stage 6: saturation products -----------------------------------------
  logic [2:0][31:0] pa6_d, pa6_q;
  logic [31:0]      pb6_d, pb6_q;

  always_comb begin
    logic [16:0] q3;
    for (int i = 0; i < 3; i++) begin
      q3       = 17'({q5_q[i], 1'b0}) + 17'(q5_q[i]);
      pa6_d[i] = 32'(sat5_q) * 32'(q3);
    end
    // grey share is common to all three channels
    pb6_d = 32'(S_FULL - sat5_q) * 32'(qs5_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      pa6_q <= pa6_d;
      pb6_q <= pb6_d;
    end
  end

  // ---- stage 7: output scale, half-denominator round, power-of-two part -----
  logic [2:0][22:0] y7_d, y7_q;

  always_comb begin
    logic [31:0] t;
    logic [40:0] num;
    for (int i = 0; i < 3; i++) begin
      t       = pa6_q[i] + pb6_q;
      num     = 41'(t) * 41'(OUT_MAX) + HALF_DEN;
      y7_d[i] = 23'(num >> DEN_SH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      y7_q <= y7_d;
    end
  end

  // ---- stage 8: divide by the remaining factor 30000 of the denominator -------
  logic [2:0][46:0] p8_d, p8_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p8_d[i] = 47'(y7_q[i]) * 47'(RECIP_DEN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      p8_q <= p8_d;
    end
  end

  // ---- stage 9: output register ---------------------------------------------
  logic [2:0][OUT_W-1:0] rgb9_d, rgb9_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rgb9_d[i] = OUT_W'(p8_q[i] >> RECIP_DEN_SH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      rgb9_q <= rgb9_d;
    end
  end

  assign m_axis_tvalid_o = vld_q[NSTG-1];
  assign m_axis_tdata_o  = {rgb9_q[2], rgb9_q[1], rgb9_q[0]};

endmodule

FILE: rtl/hrc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrc_checker
// port-level checks for the hsl to rgb pipeline, bound to the top level
// ---------------------------------------------------------------------------
`include "hsl_to_rgb_converter_core_defines.svh"

module hrc_checker import hrc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  // a stalled result stays put
  `HRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // input back-pressure only when the output holds a result that is not taken
  `HRC_ASSERT_NOW(a_ready_path, !s_axis_tready_o, m_axis_tvalid_o && !m_axis_tready_i)

  // right out of reset nothing is offered
  `HRC_ASSERT_NOW(a_reset_quiet, $past(!rst_ni), !m_axis_tvalid_o)

endmodule

bind hsl_to_rgb_converter_core hrc_checker u_hrc_checker (.*);
